// ----- src/ucv_pkg.sv -----
// Shared types and constants for the UTF-8 command text checker.
`default_nettype none

package ucv_pkg;

  localparam int unsigned CP_W = 21;

  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_ONE  = 3'd1;
  localparam logic [2:0] SEQ_TWO  = 3'd2;
  localparam logic [2:0] SEQ_THREE = 3'd3;
  localparam logic [2:0] SEQ_FOUR = 3'd4;

  localparam logic [CP_W-1:0] CP_TAB       = 21'h00009;
  localparam logic [CP_W-1:0] CP_LF        = 21'h0000A;
  localparam logic [CP_W-1:0] CP_CR        = 21'h0000D;
  localparam logic [CP_W-1:0] CP_ESC       = 21'h0001B;
  localparam logic [CP_W-1:0] CP_SPACE     = 21'h00020;
  localparam logic [CP_W-1:0] CP_DEL       = 21'h0007F;
  localparam logic [CP_W-1:0] CP_C1_LAST   = 21'h0009F;
  localparam logic [CP_W-1:0] CP_MIN_TWO   = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN_THREE = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN_FOUR  = 21'h10000;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h0D800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h0DFFF;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_LSEP      = 21'h02028;
  localparam logic [CP_W-1:0] CP_PSEP      = 21'h02029;
  localparam logic [CP_W-1:0] CP_EMB_LO    = 21'h0202A;
  localparam logic [CP_W-1:0] CP_EMB_HI    = 21'h0202E;
  localparam logic [CP_W-1:0] CP_ISO_LO    = 21'h02066;
  localparam logic [CP_W-1:0] CP_ISO_HI    = 21'h02069;

  typedef struct packed {
    logic [1:0]      pending;
    logic [2:0]      width;
    logic [CP_W-1:0] cp;
    logic            fault;
  } ucv_state_t;

endpackage

`default_nettype wire

// ----- src/ucv_cp_filter.sv -----
// Codepoint filter: overlong, range, surrogate, control and format checks.
`default_nettype none

module ucv_cp_filter
  import ucv_pkg::*;
(
  input  wire logic [CP_W-1:0] cp,
  input  wire logic [2:0]      width,
  output logic                 rejected
);

  logic overlong;
  logic range_bad;
  logic c0_bad;
  logic c1_bad;
  logic fmt_bad;

  always_comb begin
    overlong = ((width == SEQ_TWO) && (cp < CP_MIN_TWO)) ||
               ((width == SEQ_THREE) && (cp < CP_MIN_THREE)) ||
               ((width == SEQ_FOUR) && (cp < CP_MIN_FOUR));
    range_bad = (cp > CP_MAX) || (cp inside {[CP_SURR_LO:CP_SURR_HI]});
    c0_bad = (cp == CP_ESC) || (cp == CP_CR) ||
             ((cp < CP_SPACE) && (cp != CP_TAB) && (cp != CP_LF));
    c1_bad = cp inside {[CP_DEL:CP_C1_LAST]};
    fmt_bad = (cp inside {CP_LSEP, CP_PSEP}) ||
              (cp inside {[CP_EMB_LO:CP_EMB_HI]}) ||
              (cp inside {[CP_ISO_LO:CP_ISO_HI]});
    rejected = overlong || range_bad || c0_bad || c1_bad || fmt_bad;
  end

endmodule

`default_nettype wire

// ----- src/ucv_decoder.sv -----
// Decoder state and per-word sequence tracking with sticky fault.
`default_nettype none

module ucv_decoder
  import ucv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       advance,
  input  wire logic [7:0] word_byte,
  input  wire logic       word_final,
  output logic            verdict_ok
);

  ucv_state_t st;
  ucv_state_t st_next;
  logic [CP_W-1:0] chk_cp;
  logic [2:0]      chk_width;
  logic            chk_rejected;
  logic [CP_W-1:0] assembled;

  assign assembled = {st.cp[CP_W-7:0], word_byte[5:0]};

  always_comb begin
    if (st.pending == 2'd0) begin
      chk_cp    = {{(CP_W-8){1'b0}}, word_byte};
      chk_width = SEQ_ONE;
    end else begin
      chk_cp    = assembled;
      chk_width = st.width;
    end
  end

  ucv_cp_filter u_filter (
    .cp       (chk_cp),
    .width    (chk_width),
    .rejected (chk_rejected)
  );

  always_comb begin
    st_next = st;
    if (st.pending == 2'd0) begin
      if (!word_byte[7]) begin
        if (chk_rejected) st_next.fault = 1'b1;
      end else if (word_byte[7:5] == 3'b110) begin
        st_next.cp      = {{(CP_W-5){1'b0}}, word_byte[4:0]};
        st_next.width   = SEQ_TWO;
        st_next.pending = 2'd1;
      end else if (word_byte[7:4] == 4'b1110) begin
        st_next.cp      = {{(CP_W-4){1'b0}}, word_byte[3:0]};
        st_next.width   = SEQ_THREE;
        st_next.pending = 2'd2;
      end else if (word_byte[7:3] == 5'b11110) begin
        st_next.cp      = {{(CP_W-3){1'b0}}, word_byte[2:0]};
        st_next.width   = SEQ_FOUR;
        st_next.pending = 2'd3;
      end else begin
        st_next.fault = 1'b1;
      end
    end else if (word_byte[7:6] != 2'b10) begin
      st_next.fault   = 1'b1;
      st_next.pending = 2'd0;
      st_next.width   = SEQ_NONE;
      st_next.cp      = '0;
    end else if (st.pending == 2'd1) begin
      if (chk_rejected) st_next.fault = 1'b1;
      st_next.pending = 2'd0;
      st_next.width   = SEQ_NONE;
      st_next.cp      = '0;
    end else begin
      st_next.cp      = assembled;
      st_next.pending = st.pending - 2'd1;
    end
  end

  assign verdict_ok = !(st_next.fault || (st_next.pending != 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      // drop all sequence state at the end of a command
      st <= word_final ? '0 : st_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/utf8_command_validator_top.sv -----
// Top level of the UTF-8 command text checker with control filter.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | text_byte[7:0], final_byte
//  out     | output    | out_valid/out_stall | text_ok
//
// One word per cycle while in_stall is low; an accepted word waits in s1 until
// the decoder takes it; a final word loads the verdict register at that edge.
// Reset (rst, synchronous) empties both registers and clears the decoder.
// A stall on the output holds the verdict; the input stalls only when a final
// word waits behind an unaccepted verdict.
`default_nettype none

module utf8_command_validator_top
  import ucv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            text_ok
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_final;
  logic       out_free;
  logic       s1_go;
  logic       verdict_ok;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!s1_final || out_free);
  assign in_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte  <= text_byte;
      s1_final <= final_byte;
    end
  end

  ucv_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_go),
    .word_byte  (s1_byte),
    .word_final (s1_final),
    .verdict_ok (verdict_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_final) begin
      text_ok <= verdict_ok;
    end
  end

endmodule

`default_nettype wire
